/* rtl/core/anp_pkg.sv */
package anp_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_BAD = 2'd1;
  localparam logic [1:0] STATUS_OVF = 2'd2;

  // Character constants
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_LOWER_X = 8'h78;
  localparam logic [7:0] CASE_MASK    = 8'h20;

  // Digit decode results
  localparam logic [4:0] DIGIT_INVALID = 5'd16;
  localparam logic [4:0] DEC_BASE      = 5'd10;

  localparam int unsigned NUM_WIDTH     = 64;
  localparam int unsigned QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [NUM_WIDTH-1:0] number;
  } out_req_t;

  // Classified character handed from front to back
  typedef struct packed {
    logic       skip;   // hex prefix character, adds nothing
    logic       bad;    // not a digit of the current base
    logic       hex;    // base sixteen in effect
    logic [3:0] digit;
    logic       last;
  } cls_t;

  // Map a character to its digit value, DIGIT_INVALID when it is none
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c - CHAR_ZERO;
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      d = c - CHAR_LOWER_A + 8'd10;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      d = c - CHAR_UPPER_A + 8'd10;
    end else begin
      d = {3'b000, DIGIT_INVALID};
    end
    return d[4:0];
  endfunction

endpackage

/* rtl/core/anp_front.sv */
module anp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_take,
  input  anp_pkg::in_req_t in_req,
  output anp_pkg::cls_t    cls
);

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_LATER  = 2'd2;

  logic [1:0] pos_r, pos_nxt;
  logic       fwz_r, fwz_nxt;
  logic       hex_r, hex_nxt;
  logic [7:0] folded;
  logic [4:0] digit;
  logic       prefix;

  // Classify the incoming character
  always_comb begin
    folded = in_req.char_code;
    if (in_req.char_code >= anp_pkg::CHAR_UPPER_A &&
        in_req.char_code <= anp_pkg::CHAR_UPPER_Z) begin
      folded = in_req.char_code | anp_pkg::CASE_MASK;
    end
    digit  = anp_pkg::hex_digit(in_req.char_code);
    prefix = (pos_r == POS_SECOND) && fwz_r && !in_req.last_char &&
             (folded == anp_pkg::CHAR_LOWER_X);
    cls.skip  = prefix;
    cls.hex   = hex_r;
    cls.digit = digit[3:0];
    cls.bad   = hex_r ? digit[4] : (digit >= anp_pkg::DEC_BASE);
    cls.last  = in_req.last_char;
  end

  // Track position, leading zero and hex prefix per string
  always_comb begin
    pos_nxt = pos_r;
    fwz_nxt = fwz_r;
    hex_nxt = hex_r;
    if (in_take) begin
      if (in_req.last_char) begin
        pos_nxt = POS_FIRST;
        fwz_nxt = 1'b0;
        hex_nxt = 1'b0;
      end else begin
        if (pos_r != POS_LATER) begin
          pos_nxt = pos_r + 2'd1;
        end
        if (pos_r == POS_FIRST) begin
          fwz_nxt = (in_req.char_code == anp_pkg::CHAR_ZERO);
        end
        if (prefix) begin
          hex_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_FIRST;
      fwz_r <= 1'b0;
      hex_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      fwz_r <= fwz_nxt;
      hex_r <= hex_nxt;
    end
  end

endmodule

/* rtl/core/anp_queue.sv */
module anp_queue #(
  parameter int unsigned DEPTH = anp_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  anp_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output anp_pkg::cls_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  anp_pkg::cls_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/core/anp_back.sv */
module anp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  anp_pkg::cls_t     q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output anp_pkg::out_req_t out_req
);

  localparam int unsigned W = anp_pkg::NUM_WIDTH;

  logic [W-1:0]      acc_r, acc_nxt;
  logic [1:0]        err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  anp_pkg::out_req_t out_req_r;
  logic [W+3:0]      times_ten;
  logic [W+3:0]      prod;
  logic [W+4:0]      sum;
  logic              ovf;

  // Pop unless a final character would land on a held result
  assign q_pop = q_not_empty && (!q_data.last || !out_valid_r || !out_stall);

  // Multiply by base and add the digit, flag bits above the word
  always_comb begin
    times_ten = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0};
    prod      = q_data.hex ? {acc_r, 4'b0000} : times_ten;
    sum       = {1'b0, prod} + {{(W+1){1'b0}}, q_data.digit};
    ovf       = |sum[W+4:W];
  end

  // Update accumulator and first error
  always_comb begin
    acc_nxt = acc_r;
    err_nxt = err_r;
    if (err_r == anp_pkg::STATUS_OK && !q_data.skip) begin
      if (q_data.bad) begin
        err_nxt = anp_pkg::STATUS_BAD;
      end else if (ovf) begin
        err_nxt = anp_pkg::STATUS_OVF;
      end else begin
        acc_nxt = sum[W-1:0];
      end
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop && q_data.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      err_r       <= anp_pkg::STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        if (q_data.last) begin
          acc_r <= '0;
          err_r <= anp_pkg::STATUS_OK;
        end else begin
          acc_r <= acc_nxt;
          err_r <= err_nxt;
        end
      end
    end
  end

  // Capture the result of a finished string
  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      out_req_r.status <= err_nxt;
      out_req_r.number <= (err_nxt == anp_pkg::STATUS_OK) ? acc_nxt : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

/* rtl/core/ascii_number_parser.sv */
// A final character is queued, then popped into the result register.
// Throughput: one character per cycle unless the two-entry queue is full; the
// back end folds one digit per cycle, unless a held result blocks it, via a
// 68-bit multiply-by-base and add. Reset: synchronous active-low rst_n clears
// the prefix tracking, queue, accumulator, latched error and result valid.
module ascii_number_parser #(
  parameter int unsigned QUEUE_DEPTH = anp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  anp_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output anp_pkg::out_req_t out_req
);

  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  logic          in_take;
  anp_pkg::cls_t front_cls;
  anp_pkg::cls_t q_data;

  assign in_stall = q_full;
  assign in_take  = in_valid && !q_full;

  anp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_req  (in_req),
    .cls     (front_cls)
  );

  anp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  anp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_req     (out_req)
  );

endmodule
